@@ design/selective_receive_handle_queue_top_assert.svh @@
// Assertion macros for the selective receive handle queue.
`ifndef SELECTIVE_RECEIVE_HANDLE_QUEUE_TOP_ASSERT_SVH
`define SELECTIVE_RECEIVE_HANDLE_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRHQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srhq assertion failed");
`define SRHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srhq assertion failed");
`else
`define SRHQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SRHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/srhq_pkg.sv @@
// Shared types and constants of the selective receive handle queue.
`default_nettype none
package srhq_pkg;
	localparam int QUEUE_SLOTS_DEF = 16;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	localparam logic ACT_DEPOSIT = 1'b0;
	localparam logic ACT_TAKE    = 1'b1;

	typedef struct packed {
		logic [63:0] handle;
		logic [31:0] sender;
	} entry_t;
endpackage
`default_nettype wire

@@ design/srhq_ram.sv @@
// Single-port-write, registered-read mailbox entry memory.
`default_nettype none
module srhq_ram #(
	parameter int DEPTH = srhq_pkg::QUEUE_SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire                   clk,
	input  wire                   we,
	input  wire  [AW-1:0]         waddr,
	input  srhq_pkg::entry_t      wdata,
	input  wire                   re,
	input  wire  [AW-1:0]         raddr,
	output srhq_pkg::entry_t      rdata
);
	srhq_pkg::entry_t mem [DEPTH];
	srhq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ design/selective_receive_handle_queue_top.sv @@
// Top level of the selective receive handle queue.
// Usage: drive action, handle, sender and wanted_sender and raise start;
// the command beat is taken at a rising edge with start high and busy low.
// A deposit (action 0) appends (handle, sender) at the tail, or answers
// status 1 when QUEUE_SLOTS-1 entries are held. A take (action 1) finds the
// oldest entry whose sender equals wanted_sender (0 matches any), returns its
// handle with status 0 and closes the gap, or answers status 2 with handle 0.
// Each result beat shows on status and out_handle for one cycle with done high;
// the receiver cannot stall it.
// A deposit, and a take on an empty ring, answer in the cycle after the
// command and leave busy low, so such commands may follow every cycle.
// A take reads each entry from the single entry memory (S_READ, then
// S_CHECK) while scanning, then moves each older entry (S_SHIFT_RD, then
// S_SHIFT_WR) to close the gap, with busy high until the result beat.
// Reset clears head and tail (empty ring) and any pending result; the entry
// memory is not cleared since only written slots are ever read.
`default_nettype none
module selective_receive_handle_queue_top #(
	parameter int QUEUE_SLOTS = srhq_pkg::QUEUE_SLOTS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         action,
	input  wire  [63:0] handle,
	input  wire  [31:0] sender,
	input  wire  [31:0] wanted_sender,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] out_handle
);
	localparam int IW = $clog2(QUEUE_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(QUEUE_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_SHIFT_RD,
		S_SHIFT_WR
	} state_t;

	state_t        state_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [63:0]   out_handle_q;

	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [31:0]   want_q;
	logic [63:0]   found_q;

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	srhq_pkg::entry_t  mem_wdata;
	logic              mem_re;
	logic [IW-1:0]     mem_raddr;
	srhq_pkg::entry_t  mem_rdata;

	function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] s);
		slot_next = (s == LAST) ? '0 : s + IW'(1);
	endfunction

	function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] s);
		slot_prev = (s == '0) ? LAST : s - IW'(1);
	endfunction

	logic          accept;
	logic          full_w;
	logic          match_w;
	logic [IW-1:0] i_next;
	logic [IW-1:0] j_prev;

	assign accept  = start && !busy;
	assign full_w  = (slot_next(tail_q) == head_q);
	assign match_w = (want_q == 32'd0) || (mem_rdata.sender == want_q);
	assign i_next  = slot_next(i_q);
	assign j_prev  = slot_prev(j_q);

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign out_handle = out_handle_q;

	always_comb begin
		mem_we           = 1'b0;
		mem_waddr        = tail_q;
		mem_wdata.handle = handle;
		mem_wdata.sender = sender;
		mem_re           = 1'b0;
		mem_raddr        = i_q;
		case (state_q)
			S_IDLE: begin
				mem_we = accept && (action == srhq_pkg::ACT_DEPOSIT) && !full_w;
			end
			S_READ: begin
				mem_re = 1'b1;
			end
			S_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = j_prev;
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	srhq_ram #(
		.DEPTH (QUEUE_SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					i_q    <= head_q;
					want_q <= wanted_sender;
				end
			end
			S_CHECK: begin
				if (match_w) begin
					found_q <= mem_rdata.handle;
					j_q     <= i_q;
				end else begin
					i_q <= i_next;
				end
			end
			S_SHIFT_WR: begin
				j_q <= j_prev;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			done_q       <= 1'b0;
			status_q     <= srhq_pkg::ST_OK;
			out_handle_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == srhq_pkg::ACT_DEPOSIT) begin
							done_q       <= 1'b1;
							out_handle_q <= '0;
							if (full_w) begin
								status_q <= srhq_pkg::ST_FULL;
							end else begin
								status_q <= srhq_pkg::ST_OK;
								tail_q   <= slot_next(tail_q);
							end
						end else if (head_q == tail_q) begin
							done_q       <= 1'b1;
							status_q     <= srhq_pkg::ST_NOMATCH;
							out_handle_q <= '0;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (match_w) begin
						if (i_q == head_q) begin
							head_q       <= slot_next(head_q);
							done_q       <= 1'b1;
							status_q     <= srhq_pkg::ST_OK;
							out_handle_q <= mem_rdata.handle;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_SHIFT_RD;
						end
					end else if (i_next == tail_q) begin
						done_q       <= 1'b1;
						status_q     <= srhq_pkg::ST_NOMATCH;
						out_handle_q <= '0;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (j_prev == head_q) begin
						head_q       <= slot_next(head_q);
						done_q       <= 1'b1;
						status_q     <= srhq_pkg::ST_OK;
						out_handle_q <= found_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "selective_receive_handle_queue_top_assert.svh"

	`SRHQ_ASSERT_SAME(a_fail_no_handle, clk, arst_n,
		done && (status != srhq_pkg::ST_OK), out_handle == 64'd0)
	`SRHQ_ASSERT_NEXT(a_empty_take_nomatch, clk, arst_n,
		accept && (action == srhq_pkg::ACT_TAKE) && (head_q == tail_q),
		done && (status == srhq_pkg::ST_NOMATCH))
	`SRHQ_ASSERT_NEXT(a_deposit_nonempty, clk, arst_n,
		accept && (action == srhq_pkg::ACT_DEPOSIT) && !full_w,
		(tail_q != head_q) && done && (status == srhq_pkg::ST_OK))
endmodule
`default_nettype wire
